### rtl/pet_pkg.sv
// Shared types, constants and helpers for the polygon edge tessellator.
`timescale 1ns / 1ps
package pet_pkg;

  localparam int CoordFracBits = 16;
  localparam int WidthFracBits = 16;
  localparam int UnitFracBits  = 30;
  // Rounding shift of the offset product down to coordinate units.
  localparam int OffShift = UnitFracBits + WidthFracBits + 1 - CoordFracBits;

  // Short-edge threshold: 1e-4 in coordinate units, at least one LSB.
  localparam int ThRaw = ((1 << CoordFracBits) + 5000) / 10000;
  localparam int Th    = (ThRaw == 0) ? 1 : ThRaw;
  localparam logic [63:0] ThSq = 64'(Th) * 64'(Th);

  localparam logic [23:0] VertexLimitReset = 24'd65536;

  // Vertex selectors for the emit step.
  localparam logic [3:0] VSEL_Q0 = 4'd0;  // start + n
  localparam logic [3:0] VSEL_Q1 = 4'd1;  // start - n
  localparam logic [3:0] VSEL_Q2 = 4'd2;  // end + n
  localparam logic [3:0] VSEL_Q3 = 4'd3;  // start - n
  localparam logic [3:0] VSEL_Q4 = 4'd4;  // end - n
  localparam logic [3:0] VSEL_Q5 = 4'd5;  // end + n
  localparam logic [3:0] VSEL_C  = 4'd6;  // center
  localparam logic [3:0] VSEL_S  = 4'd7;  // start
  localparam logic [3:0] VSEL_E  = 4'd8;  // end

  typedef struct packed {
    logic        load;      // capture input item
    logic        sq_start;  // begin square root
    logic        dv_start;  // begin both divisions
    logic        off_calc;  // compute offsets from quotients
    logic        emit;      // load output register
    logic [3:0]  vsel;
    logic        last;
  } pet_cmd_t;

  typedef struct packed {
    logic skip_quad;   // no border or short edge
    logic sq_done;
    logic dv_done;
  } pet_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### rtl/pet_datapath.sv
// Datapath: edge capture, serial square root and division, offsets, vertex output.
`timescale 1ns / 1ps
module pet_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pet_pkg::pet_cmd_t   cmd,
  output pet_pkg::pet_sts_t   sts,
  input  logic [263:0]        in_item,
  output logic [31:0]         vx,
  output logic [31:0]         vy,
  output logic [23:0]         vrgb,
  output logic                vlast
);

  logic signed [31:0] x1_r, y1_r, x2_r, y2_r, cx_r, cy_r;
  logic [23:0] fill_r, edge_rgb_r, bw_r;
  logic        negx_r, negy_r, skip_r;
  logic [31:0] ax_r, ay_r;

  // Edge deltas on load.
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [31:0] axn, ayn;
  logic        huge;
  logic [63:0] lensq;
  assign dx  = 33'($signed(in_item[95:64])) - 33'($signed(in_item[31:0]));
  assign dy  = 33'($signed(in_item[127:96])) - 33'($signed(in_item[63:32]));
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign huge = adx[32] | adx[31] | ady[32] | ady[31];
  assign axn = huge ? {1'b0, adx[32:2]} : adx[31:0];
  assign ayn = huge ? {1'b0, ady[32:2]} : ady[31:0];

  // Squared length, registered products before the add.
  logic [63:0] sqx_r, sqy_r;
  logic        huge_r;
  assign lensq = sqx_r + sqy_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r <= $signed(in_item[31:0]);
      y1_r <= $signed(in_item[63:32]);
      x2_r <= $signed(in_item[95:64]);
      y2_r <= $signed(in_item[127:96]);
      cx_r <= $signed(in_item[159:128]);
      cy_r <= $signed(in_item[191:160]);
      fill_r     <= in_item[215:192];
      edge_rgb_r <= in_item[239:216];
      bw_r       <= in_item[263:240];
      negx_r <= dx[32];
      negy_r <= dy[32];
      ax_r   <= axn;
      ay_r   <= ayn;
      huge_r <= huge;
      sqx_r  <= 64'(axn) * 64'(axn);
      sqy_r  <= 64'(ayn) * 64'(ayn);
    end
  end

  // Square root, two bits per cycle.
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic        sq_busy_r;
  logic [63:0] sq_sum;
  assign sq_sum = sq_res_r + sq_bit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sq_start) begin
      sq_busy_r <= 1'b1;
      sq_v_r    <= lensq;
      sq_res_r  <= '0;
      sq_bit_r  <= 64'h4000_0000_0000_0000;
    end else if (sq_busy_r) begin
      if (sq_bit_r == 64'd0) begin
        sq_busy_r <= 1'b0;
      end else begin
        if (sq_v_r >= sq_sum) begin
          sq_v_r   <= sq_v_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load) skip_r <= 1'b0;
    else if (cmd.sq_start) skip_r <= (bw_r == 24'd0) || (!huge_r && lensq < pet_pkg::ThSq);
  end

  // Two restoring dividers in parallel, one quotient bit per cycle.
  logic [61:0] qx_r, qy_r;
  logic [62:0] rx_r, ry_r;
  logic [61:0] nx_sh_r, ny_sh_r;
  logic [6:0]  dv_cnt_r;
  logic [31:0] len;
  logic [62:0] rx_t, ry_t;
  assign len  = sq_res_r[31:0];
  assign rx_t = {rx_r[61:0], nx_sh_r[61]};
  assign ry_t = {ry_r[61:0], ny_sh_r[61]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (cmd.dv_start) begin
      dv_cnt_r <= 7'd62;
      nx_sh_r  <= {ax_r, 30'd0};
      ny_sh_r  <= {ay_r, 30'd0};
      rx_r <= '0; ry_r <= '0; qx_r <= '0; qy_r <= '0;
    end else if (dv_cnt_r != 7'd0) begin
      dv_cnt_r <= dv_cnt_r - 7'd1;
      nx_sh_r  <= nx_sh_r << 1;
      ny_sh_r  <= ny_sh_r << 1;
      if (rx_t >= 63'(len)) begin
        rx_r <= rx_t - 63'(len); qx_r <= {qx_r[60:0], 1'b1};
      end else begin
        rx_r <= rx_t; qx_r <= {qx_r[60:0], 1'b0};
      end
      if (ry_t >= 63'(len)) begin
        ry_r <= ry_t - 63'(len); qy_r <= {qy_r[60:0], 1'b1};
      end else begin
        ry_r <= ry_t; qy_r <= {qy_r[60:0], 1'b0};
      end
    end
  end

  assign sts = '{skip_quad: skip_r,
                 sq_done:   !sq_busy_r && !cmd.sq_start,
                 dv_done:   (dv_cnt_r == 7'd0) && !cmd.dv_start};

  // Offsets: unit components stay below 2^31, products below 2^55.
  logic [55:0] px_r, py_r;
  logic [55:0] rndx, rndy;
  logic signed [32:0] offx_r, offy_r; // offx = -half(uy), offy = half(ux)
  logic [31:0] hx, hy;
  logic        off_stage_r;
  assign rndx = px_r + (56'd1 << (pet_pkg::OffShift - 1));
  assign rndy = py_r + (56'd1 << (pet_pkg::OffShift - 1));
  assign hx = 32'(rndx >> pet_pkg::OffShift);
  assign hy = 32'(rndy >> pet_pkg::OffShift);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_stage_r <= 1'b0;
    end else begin
      off_stage_r <= cmd.off_calc;
    end
    if (cmd.off_calc) begin
      px_r <= 56'(qx_r[31:0]) * 56'(bw_r);
      py_r <= 56'(qy_r[31:0]) * 56'(bw_r);
    end
    if (off_stage_r) begin
      offy_r <= negx_r ? -33'(hx) : 33'(hx);
      offx_r <= negy_r ? 33'(hy) : -33'(hy);
    end
  end

  // Vertex select and output data.
  logic signed [33:0] sx, sy;
  always_comb begin
    sx = 34'(x1_r); sy = 34'(y1_r);
    case (cmd.vsel)
      pet_pkg::VSEL_Q0: begin sx = 34'(x1_r) + 34'(offx_r); sy = 34'(y1_r) + 34'(offy_r); end
      pet_pkg::VSEL_Q1,
      pet_pkg::VSEL_Q3: begin sx = 34'(x1_r) - 34'(offx_r); sy = 34'(y1_r) - 34'(offy_r); end
      pet_pkg::VSEL_Q2,
      pet_pkg::VSEL_Q5: begin sx = 34'(x2_r) + 34'(offx_r); sy = 34'(y2_r) + 34'(offy_r); end
      pet_pkg::VSEL_Q4: begin sx = 34'(x2_r) - 34'(offx_r); sy = 34'(y2_r) - 34'(offy_r); end
      pet_pkg::VSEL_C:  begin sx = 34'(cx_r); sy = 34'(cy_r); end
      pet_pkg::VSEL_S:  begin sx = 34'(x1_r); sy = 34'(y1_r); end
      pet_pkg::VSEL_E:  begin sx = 34'(x2_r); sy = 34'(y2_r); end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vx    <= pet_pkg::sat32(sx);
      vy    <= pet_pkg::sat32(sy);
      vrgb  <= (cmd.vsel < pet_pkg::VSEL_C) ? edge_rgb_r : fill_r;
      vlast <= cmd.last;
    end
  end

endmodule

### rtl/pet_ctrl.sv
// Controller: handshakes, capacity check and vertex sequencing.
`timescale 1ns / 1ps
module pet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       bw,
  input  logic [11:0]       n,
  input  logic              first,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [23:0]       cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output pet_pkg::pet_cmd_t cmd,
  input  pet_pkg::pet_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_DV   = 3'd2;
  localparam logic [2:0] S_OFF  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_SQW  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [23:0] limit_r, total_r, total_nxt;
  logic        halted_r, halted_nxt;
  logic [3:0]  vsel_r, vsel_nxt;
  logic [2:0]  off_cnt_r, off_cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [4:0]  emitted_r, emitted_nxt;

  logic        accept;
  logic [15:0] need;
  logic [24:0] sum;
  logic        slot_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign need = (bw != 24'd0) ? 16'(n) * 16'd9 : 16'(n) * 16'd3;
  assign sum  = 25'(total_r) + 25'(need);
  assign slot_free = !ov_r || out_tready;
  assign out_tvalid = ov_r;

  always_comb begin
    state_nxt = state_r; total_nxt = total_r; halted_nxt = halted_r;
    vsel_nxt = vsel_r; off_cnt_nxt = off_cnt_r; emitted_nxt = emitted_r;
    ov_nxt = ov_r && !out_tready;
    cmd = '0;
    cmd.vsel = vsel_r;
    cmd.last = (vsel_r == pet_pkg::VSEL_E);
    cmd.load = accept;
    case (state_r)
      S_IDLE: begin
        if (accept && !halted_r && n >= 12'd3) begin
          if (first && sum > 25'(limit_r)) begin
            halted_nxt = 1'b1;
          end else begin
            emitted_nxt = '0;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.sq_start = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (sts.sq_done) begin
          if (sts.skip_quad) begin
            vsel_nxt = pet_pkg::VSEL_C;
            state_nxt = S_EMIT;
          end else begin
            cmd.dv_start = 1'b1;
            state_nxt = S_DV;
          end
        end
      end
      S_DV: begin
        if (sts.dv_done) begin
          cmd.off_calc = 1'b1;
          off_cnt_nxt = 3'd2;
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        off_cnt_nxt = off_cnt_r - 3'd1;
        if (off_cnt_r == 3'd1) begin
          vsel_nxt = pet_pkg::VSEL_Q0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          ov_nxt = 1'b1;
          emitted_nxt = emitted_r + 5'd1;
          if (vsel_r == pet_pkg::VSEL_E) begin
            total_nxt = (25'(total_r) + 25'(emitted_r) + 25'd1 > 25'hFFFFFF) ?
                        24'hFFFFFF : 24'(25'(total_r) + 25'(emitted_r) + 25'd1);
            state_nxt = S_IDLE;
          end else begin
            vsel_nxt = vsel_r + 4'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; total_r <= '0; halted_r <= 1'b0; limit_r <= pet_pkg::VertexLimitReset;
      vsel_r <= '0; off_cnt_r <= '0; ov_r <= 1'b0; emitted_r <= '0;
    end else begin
      state_r <= state_nxt; total_r <= total_nxt; halted_r <= halted_nxt;
      vsel_r <= vsel_nxt; off_cnt_r <= off_cnt_nxt; ov_r <= ov_nxt; emitted_r <= emitted_nxt;
      if (cfg_valid) limit_r <= cfg_data;
    end
  end

  // Input is only taken when idle, and a halted block never leaves idle.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halted_r) |-> halted_r) else $error("halt cleared");
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && state_r == S_IDLE |=> state_r == S_IDLE) else $error("halted block started");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ov_r || out_tready)) else $error("output overwritten");

endmodule

### rtl/polygon_edge_tessellator_top.sv
// Top level of the polygon edge tessellator.
//
// Usage: one polygon edge per in_ transaction, up to nine vertices back on
// out_ (six border quad vertices, then center, start and end of the fan
// triangle; out_tlast marks the end vertex). in_tuser flags the first edge of
// a polygon. cfg_ writes the 24-bit vertex limit; cfg_ready is always high,
// so write it only between edges.
// The 32-step square root runs for every edge. A bordered edge adds the
// 62-step divider pair and the offset stages. Vertices then go out one per
// cycle while out_tready is high.
// The serial square root and dividers set the item time; one edge is in
// flight at a time and in_tready is high only between edges.
// Reset (rst_n low, synchronous) clears the vertex total and the halt flag
// and sets the limit to 65536. A capacity overflow on a first edge halts all
// later output until reset. When the receiver stalls, the output register
// holds its vertex and the sequence waits until the receiver takes it.
`timescale 1ns / 1ps
module polygon_edge_tessellator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_start, y_start, x_end, y_end, center_x, center_y, fill_rgb,
  // border_rgb, outline_w, edge_count, zero pad
  input  logic [279:0] in_tdata,
  // first_edge
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // px, py, rgb
  output logic [87:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);

  pet_pkg::pet_cmd_t cmd;
  pet_pkg::pet_sts_t sts;
  logic [31:0] vx, vy;
  logic [23:0] vrgb;

  pet_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_item(in_tdata[263:0]),
    .vx(vx), .vy(vy), .vrgb(vrgb), .vlast(out_tlast)
  );

  pet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .bw(in_tdata[263:240]), .n(in_tdata[275:264]), .first(in_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  assign out_tdata = {vrgb, vy, vx};

endmodule
